// ===== design/srtpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srtpq_pkg;

  localparam int OCC_BITS = 4;

  // input kind codes
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic       load;    // capture a result beat
    logic       ins;     // insert the incoming item
    logic       rem;     // pop the head entry
    logic [1:0] code;    // status to report
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/srtpq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srtpq_datapath #(
  parameter int DEPTH     = 8,
  parameter int PRIO_BITS = 8,
  parameter int DATA_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire srtpq_pkg::cmd_t         cmd,
  output srtpq_pkg::stat_t             stat,
  input  wire logic [DATA_BITS-1:0]    item_data,
  input  wire logic [PRIO_BITS-1:0]    item_priority,
  output logic [1:0]                   status,
  output logic [DATA_BITS-1:0]         out_data,
  output logic [PRIO_BITS-1:0]         out_priority,
  output logic [srtpq_pkg::OCC_BITS-1:0] occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] cell_data [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio [DEPTH];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic [DEPTH-1:0]     le;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  // le is a prefix mask: occupied cells that the new item goes behind
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count) && (cell_prio[i] <= item_priority);
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic open_here;
    if (g == 0) begin : g_first
      assign open_here = 1'b1;
    end else begin : g_rest
      assign open_here = le[g-1];
    end

    always_ff @(posedge clk) begin
      if (cmd.ins && !le[g]) begin
        if (open_here) begin
          cell_data[g] <= item_data;
          cell_prio[g] <= item_priority;
        end else begin
          cell_data[g] <= cell_data[(g > 0) ? g - 1 : 0];
          cell_prio[g] <= cell_prio[(g > 0) ? g - 1 : 0];
        end
      end else if (cmd.rem && g < DEPTH - 1) begin
        cell_data[g] <= cell_data[(g < DEPTH - 1) ? g + 1 : g];
        cell_prio[g] <= cell_prio[(g < DEPTH - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= cmd.code;
      out_data     <= cmd.rem ? cell_data[0] : '0;
      out_priority <= cmd.rem ? cell_prio[0] : '0;
      occupancy    <= srtpq_pkg::OCC_BITS'(count_next);
    end
  end

endmodule

`default_nettype wire

// ===== design/srtpq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srtpq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             kind,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire srtpq_pkg::stat_t stat,
  output srtpq_pkg::cmd_t       cmd
);

  typedef enum logic {
    S_EMPTY,
    S_HELD
  } state_t;

  state_t state;
  logic   accept;

  // result slot is free when empty or being drained this cycle
  assign in_stall  = (state == S_HELD) && out_stall;
  assign out_valid = (state == S_HELD);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    cmd.code = srtpq_pkg::ST_OK;
    if (accept) begin
      if (kind == srtpq_pkg::KIND_ENQ) begin
        if (stat.full) begin
          cmd.code = srtpq_pkg::ST_OVERFLOW;
        end else begin
          cmd.ins = 1'b1;
        end
      end else begin
        if (stat.empty) begin
          cmd.code = srtpq_pkg::ST_UNDERFLOW;
        end else begin
          cmd.rem = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
    end else begin
      case (state)
        S_EMPTY: begin
          if (accept) begin
            state <= S_HELD;
          end
        end
        S_HELD: begin
          if (!out_stall && !accept) begin
            state <= S_EMPTY;
          end
        end
        default: state <= S_EMPTY;
      endcase
    end
  end

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.rem))
    else $error("insert and remove issued together");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> !stat.full)
    else $error("insert into a full queue");

  a_rem_avail: assert property (@(posedge clk) disable iff (rst)
    cmd.rem |-> !stat.empty)
    else $error("remove from an empty queue");

  a_held_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result beat dropped");

endmodule

`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Sorted priority queue, up to DEPTH entries held in ascending priority order.
// Input channel (in_valid / in_stall): one beat is one command. kind selects
// enqueue (item_data, item_priority) or dequeue; equal priorities leave in
// arrival order. Output channel (out_valid / out_stall): exactly one result
// beat per command with status (ok, overflow, underflow), the dequeued data
// and priority (zero otherwise) and the occupancy after the command.
// The result beat appears the cycle after acceptance. Throughput is one command
// per cycle unless out_stall holds a result; every register cell compares
// against the incoming priority in parallel and shifts in the same cycle.
// The single result register is the only buffering: while a result waits
// under out_stall, in_stall is raised and no new command is taken. The
// result beat holds steady until taken.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// cell contents are not cleared, cells past the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH     = 8,
  parameter int PRIO_BITS = 8,
  parameter int DATA_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          kind,
  input  wire logic signed [DATA_BITS-1:0]   item_data,
  input  wire logic [PRIO_BITS-1:0]          item_priority,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic signed [DATA_BITS-1:0]        out_data,
  output logic [PRIO_BITS-1:0]               out_priority,
  output logic [srtpq_pkg::OCC_BITS-1:0]     occupancy
);

  srtpq_pkg::cmd_t  cmd;
  srtpq_pkg::stat_t stat;

  srtpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  srtpq_datapath #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .item_data     (item_data),
    .item_priority (item_priority),
    .status        (status),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .occupancy     (occupancy)
  );

endmodule

`default_nettype wire
